FILE: rtl/core/gbr_pkg.sv
// Shared types, constants and helper functions for the renormalized RGB blur.
// Depends on nothing; every other file but gbr_ram imports it.
package gbr_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int KERNEL_SPAN = 5;
    localparam int KHALF       = KERNEL_SPAN / 2;
    localparam int LINE_DEPTH  = 4 * MAX_WIDTH + 8;
    localparam int ADDR_W      = $clog2(LINE_DEPTH);

    localparam int DIM_W   = 12;
    localparam int WT_W    = 16;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int CNT_W   = 23;
    localparam int ACC_W   = 30;
    localparam int WSUM_W  = 22;
    localparam int QBITS   = 9;
    localparam int TAP_W   = 3;
    localparam int STEP_W  = 5;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CENTER    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_EDGE_NEAR = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DIAG_NEAR = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_EDGE_FAR  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_KNIGHT    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CORNER    = 4'd7;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [WT_W-1:0]  weight_center;
        logic [WT_W-1:0]  weight_edge_near;
        logic [WT_W-1:0]  weight_diag_near;
        logic [WT_W-1:0]  weight_edge_far;
        logic [WT_W-1:0]  weight_knight;
        logic [WT_W-1:0]  weight_corner;
    } cfg_t;

    typedef struct packed {
        logic             accept;
        logic             rc_step;
        logic             tap_acc;
        logic             div_init;
        logic             div_step;
        logic             load_out;
        logic [TAP_W-1:0] tap_i;
        logic [TAP_W-1:0] tap_j;
    } cmd_t;

    typedef struct packed {
        logic produce;
        logic out_busy;
    } sts_t;

    function automatic logic [WT_W-1:0] weight_sel(input logic [4:0] d2, input cfg_t c);
        logic [WT_W-1:0] w;
        case (d2)
            5'd0:    w = c.weight_center;
            5'd1:    w = c.weight_edge_near;
            5'd2:    w = c.weight_diag_near;
            5'd4:    w = c.weight_edge_far;
            5'd5:    w = c.weight_knight;
            5'd8:    w = c.weight_corner;
            default: w = '0;
        endcase
        return w;
    endfunction

    // Rounds quotient and remainder to nearest, ties to even, then saturates; a zero denominator gives zero.
    function automatic logic [CH_W-1:0] round_sat(input logic [QBITS-1:0] q,
                                                   input logic [ACC_W-1:0] r,
                                                   input logic [WSUM_W-1:0] den);
        logic [ACC_W:0]  r2;
        logic [QBITS:0]  qr;
        logic            up;
        r2 = {r, 1'b0};
        up = (r2 > (ACC_W+1)'(den)) || ((r2 == (ACC_W+1)'(den)) && q[0]);
        qr = {1'b0, q} + (QBITS+1)'(up);
        if (den == '0) begin
            return '0;
        end
        if (qr > (QBITS+1)'(255)) begin
            return 8'd255;
        end
        return qr[CH_W-1:0];
    endfunction

endpackage

FILE: rtl/core/gbr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module gbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8200
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/gbr_ctrl.sv
// Sequencer of the blur: steps the row/column divide, the 25 taps and the
// channel divides. Depends on gbr_pkg.
module gbr_ctrl import gbr_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RC   = 3'd1;
    localparam logic [2:0] S_TRD  = 3'd2;
    localparam logic [2:0] S_TACC = 3'd3;
    localparam logic [2:0] S_DIVI = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [TAP_W-1:0] tap_i_reg, tap_i_next;
    logic [TAP_W-1:0] tap_j_reg, tap_j_next;
    logic             last_tap;

    assign in_ready = (state_reg == S_IDLE);
    assign last_tap = (tap_i_reg == TAP_W'(KERNEL_SPAN-1)) && (tap_j_reg == TAP_W'(KERNEL_SPAN-1));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        tap_i_next = tap_i_reg;
        tap_j_next = tap_j_reg;
        cmd        = '0;
        cmd.tap_i  = tap_i_reg;
        cmd.tap_j  = tap_j_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.produce)
                    begin
                        state_next = S_RC;
                        step_next  = '0;
                    end
                end
            end
            S_RC:
            begin
                cmd.rc_step = 1'b1;
                step_next   = step_reg + 1'b1;
                if (step_reg == STEP_W'(CNT_W-1))
                begin
                    state_next = S_TRD;
                    tap_i_next = '0;
                    tap_j_next = '0;
                end
            end
            S_TRD:
            begin
                state_next = S_TACC;
            end
            S_TACC:
            begin
                cmd.tap_acc = 1'b1;
                if (last_tap)
                begin
                    state_next = S_DIVI;
                end
                else
                begin
                    state_next = S_TRD;
                    if (tap_j_reg == TAP_W'(KERNEL_SPAN-1))
                    begin
                        tap_j_next = '0;
                        tap_i_next = tap_i_reg + 1'b1;
                    end
                    else
                    begin
                        tap_j_next = tap_j_reg + 1'b1;
                    end
                end
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(QBITS-1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            tap_i_reg <= '0;
            tap_j_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            tap_i_reg <= tap_i_next;
            tap_j_reg <= tap_j_next;
        end
    end

    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        (tap_i_reg < TAP_W'(KERNEL_SPAN)) && (tap_j_reg < TAP_W'(KERNEL_SPAN)))
        else $error("tap counter out of range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !sts.out_busy)
        else $error("result loaded over a waiting item");

    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && !sts.produce) |=> (state_reg == S_IDLE))
        else $error("item without result left idle");

    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_DONE) |-> ($past(state_reg) == S_DIV))
        else $error("result stage entered out of order");

endmodule

FILE: rtl/core/gbr_dp.sv
// Datapath of the blur: configuration, frame counters, pixel store, tap
// accumulation, dividers and output register. Depends on gbr_pkg and gbr_ram.
module gbr_dp import gbr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output sts_t                  sts,
    input  logic                  op,
    input  logic [CH_W-1:0]       pixel_red,
    input  logic [CH_W-1:0]       pixel_green,
    input  logic [CH_W-1:0]       pixel_blue,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [CH_W-1:0]       out_red,
    output logic [CH_W-1:0]       out_green,
    output logic [CH_W-1:0]       out_blue,
    output logic                  frame_last
);

    cfg_t cfg_reg;

    logic [CNT_W-1:0]  in_cnt_reg, out_cnt_reg;
    logic [ADDR_W-1:0] in_mod_reg, out_mod_reg;
    logic [CNT_W-1:0]  p_reg;
    logic [ADDR_W-1:0] pmod_reg;
    logic              last_reg;

    logic [DIM_W:0]    rc_rem_reg;
    logic [DIM_W-1:0]  row_reg;

    logic [ACC_W-1:0]  sr_reg, sg_reg, sb_reg;
    logic [WSUM_W-1:0] ws_reg;
    logic [ACC_W-1:0]  den_reg;
    logic [QBITS-1:0]  qr_reg, qg_reg, qb_reg;

    logic              out_valid_reg, last_out_reg;
    logic [CH_W-1:0]   red_reg, green_reg, blue_reg;

    logic [DIM_W-1:0]  eff_w, eff_h;
    logic [CNT_W-1:0]  n_pix, lag;
    logic              clr, in_range, drop, produce, wr_en, inc;
    logic [CNT_W-1:0]  ic, oc, ic1, oc1;
    logic [ADDR_W-1:0] im, om, im1, om1;

    // Frame geometry, clamped to the supported range.
    always_comb
    begin
        if (cfg_reg.image_width == '0)
            eff_w = DIM_W'(1);
        else if (cfg_reg.image_width > DIM_W'(MAX_WIDTH))
            eff_w = DIM_W'(MAX_WIDTH);
        else
            eff_w = cfg_reg.image_width;
        if (cfg_reg.image_height == '0)
            eff_h = DIM_W'(1);
        else if (cfg_reg.image_height > DIM_W'(MAX_HEIGHT))
            eff_h = DIM_W'(MAX_HEIGHT);
        else
            eff_h = cfg_reg.image_height;
    end

    assign n_pix = CNT_W'(eff_w * eff_h);
    assign lag   = CNT_W'({eff_w, 1'b0}) + CNT_W'(2);

    // A frame that is already complete restarts at the next item.
    assign clr      = (out_cnt_reg >= n_pix);
    assign ic       = clr ? '0 : in_cnt_reg;
    assign im       = clr ? '0 : in_mod_reg;
    assign oc       = clr ? '0 : out_cnt_reg;
    assign om       = clr ? '0 : out_mod_reg;
    assign in_range = (ic < n_pix);
    assign drop     = in_range && (op == OP_FLUSH);
    assign produce  = !drop && (ic >= lag);
    assign wr_en    = cmd.accept && in_range && (op == OP_PIXEL);
    assign inc      = (ic != COUNT_MAX);
    assign ic1      = inc ? ic + 1'b1 : ic;
    assign im1      = !inc ? im : (im == ADDR_W'(LINE_DEPTH-1)) ? '0 : im + 1'b1;
    assign oc1      = oc + 1'b1;
    assign om1      = (om == ADDR_W'(LINE_DEPTH-1)) ? '0 : om + 1'b1;

    assign sts.produce  = produce;
    assign sts.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width      <= 12'd640;
            cfg_reg.image_height     <= 12'd480;
            cfg_reg.weight_center    <= 16'd10624;
            cfg_reg.weight_edge_near <= 16'd6443;
            cfg_reg.weight_diag_near <= 16'd3907;
            cfg_reg.weight_edge_far  <= 16'd1436;
            cfg_reg.weight_knight    <= 16'd871;
            cfg_reg.weight_corner    <= 16'd194;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:      cfg_reg.image_width      <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:     cfg_reg.image_height     <= cfg_data[DIM_W-1:0];
                REG_WEIGHT_CENTER:    cfg_reg.weight_center    <= cfg_data;
                REG_WEIGHT_EDGE_NEAR: cfg_reg.weight_edge_near <= cfg_data;
                REG_WEIGHT_DIAG_NEAR: cfg_reg.weight_diag_near <= cfg_data;
                REG_WEIGHT_EDGE_FAR:  cfg_reg.weight_edge_far  <= cfg_data;
                REG_WEIGHT_KNIGHT:    cfg_reg.weight_knight    <= cfg_data;
                REG_WEIGHT_CORNER:    cfg_reg.weight_corner    <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            in_mod_reg  <= '0;
            out_cnt_reg <= '0;
            out_mod_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (drop)
            begin
                in_cnt_reg  <= ic;
                in_mod_reg  <= im;
                out_cnt_reg <= oc;
                out_mod_reg <= om;
            end
            else if (produce && (oc1 >= n_pix))
            begin
                in_cnt_reg  <= '0;
                in_mod_reg  <= '0;
                out_cnt_reg <= '0;
                out_mod_reg <= '0;
            end
            else if (produce)
            begin
                in_cnt_reg  <= ic1;
                in_mod_reg  <= im1;
                out_cnt_reg <= oc1;
                out_mod_reg <= om1;
            end
            else
            begin
                in_cnt_reg  <= ic1;
                in_mod_reg  <= im1;
                out_cnt_reg <= oc;
                out_mod_reg <= om;
            end
        end
    end

    // Tap geometry for the current kernel position.
    logic signed [3:0]  dx, dy;
    logic [3:0]         adx, ady;
    logic [4:0]         d2;
    logic signed [16:0] dx_w, off, addr_s, addr_f;
    logic signed [13:0] tx, ty;
    logic               tap_ok;
    logic [WT_W-1:0]    wt;
    logic [ADDR_W-1:0]  rd_addr;
    logic [PIX_W-1:0]   rd_data;

    assign dx     = $signed({1'b0, cmd.tap_i}) - $signed(4'(KHALF));
    assign dy     = $signed({1'b0, cmd.tap_j}) - $signed(4'(KHALF));
    assign adx    = dx[3] ? 4'(-dx) : dx;
    assign ady    = dy[3] ? 4'(-dy) : dy;
    assign d2     = 5'(adx * adx) + 5'(ady * ady);
    assign dx_w   = 17'(dx * $signed({1'b0, eff_w}));
    assign off    = dx_w + {{13{dy[3]}}, dy};
    assign addr_s = $signed({3'b000, pmod_reg}) + off;
    assign addr_f = addr_s[16] ? addr_s + 17'(LINE_DEPTH)
                  : (addr_s >= 17'(LINE_DEPTH)) ? addr_s - 17'(LINE_DEPTH) : addr_s;
    assign rd_addr = addr_f[ADDR_W-1:0];
    assign tx     = $signed({2'b00, row_reg}) + {{10{dx[3]}}, dx};
    assign ty     = $signed({1'b0, rc_rem_reg}) + {{10{dy[3]}}, dy};
    assign tap_ok = !tx[13] && (tx < $signed({2'b00, eff_h}))
                 && !ty[13] && (ty < $signed({2'b00, eff_w}));
    assign wt     = weight_sel(d2, cfg_reg);

    gbr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (im),
        .wr_data ({pixel_red, pixel_green, pixel_blue}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Row and column of the output position come out of a bit-serial divide.
    logic [DIM_W:0] rc_try;
    assign rc_try = {rc_rem_reg[DIM_W-1:0], p_reg[CNT_W-1]};

    logic [ACC_W-1:0] sub_r, sub_g, sub_b;
    assign sub_r = sr_reg - den_reg;
    assign sub_g = sg_reg - den_reg;
    assign sub_b = sb_reg - den_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && produce)
        begin
            p_reg      <= oc;
            pmod_reg   <= om;
            last_reg   <= (oc1 >= n_pix);
            rc_rem_reg <= '0;
            row_reg    <= '0;
            sr_reg     <= '0;
            sg_reg     <= '0;
            sb_reg     <= '0;
            ws_reg     <= '0;
        end
        if (cmd.rc_step)
        begin
            p_reg <= {p_reg[CNT_W-2:0], 1'b0};
            if (rc_try >= {1'b0, eff_w})
            begin
                rc_rem_reg <= rc_try - {1'b0, eff_w};
                row_reg    <= {row_reg[DIM_W-2:0], 1'b1};
            end
            else
            begin
                rc_rem_reg <= rc_try;
                row_reg    <= {row_reg[DIM_W-2:0], 1'b0};
            end
        end
        if (cmd.tap_acc && tap_ok)
        begin
            ws_reg <= ws_reg + WSUM_W'(wt);
            sr_reg <= sr_reg + ACC_W'(wt * rd_data[3*CH_W-1:2*CH_W]);
            sg_reg <= sg_reg + ACC_W'(wt * rd_data[2*CH_W-1:CH_W]);
            sb_reg <= sb_reg + ACC_W'(wt * rd_data[CH_W-1:0]);
        end
        if (cmd.div_init)
        begin
            den_reg <= ACC_W'({ws_reg, {(QBITS-1){1'b0}}});
            qr_reg  <= '0;
            qg_reg  <= '0;
            qb_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            den_reg <= {1'b0, den_reg[ACC_W-1:1]};
            if (sr_reg >= den_reg)
            begin
                sr_reg <= sub_r;
            end
            if (sg_reg >= den_reg)
            begin
                sg_reg <= sub_g;
            end
            if (sb_reg >= den_reg)
            begin
                sb_reg <= sub_b;
            end
            qr_reg <= {qr_reg[QBITS-2:0], sr_reg >= den_reg};
            qg_reg <= {qg_reg[QBITS-2:0], sg_reg >= den_reg};
            qb_reg <= {qb_reg[QBITS-2:0], sb_reg >= den_reg};
        end
        if (cmd.load_out)
        begin
            red_reg      <= round_sat(qr_reg, sr_reg, ws_reg);
            green_reg    <= round_sat(qg_reg, sg_reg, ws_reg);
            blue_reg     <= round_sat(qb_reg, sb_reg, ws_reg);
            last_out_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = red_reg;
    assign out_green  = green_reg;
    assign out_blue   = blue_reg;
    assign frame_last = last_out_reg;

endmodule

FILE: rtl/core/gaussian_blur_rgb_renormalized.sv
// Top level of the 5x5 RGB blur with border renormalization.
// Depends on gbr_pkg, gbr_ctrl, gbr_dp and gbr_ram.
//
// Usage: pixels enter in raster order on the in_valid/in_ready channel, one
// item each (op = 0 for a pixel, op = 1 for a flush item). The output pixel for
// a position comes back 2*width+2 items later; flush items at the end of a
// frame drain that lag, and frame_last marks the final pixel of the frame.
// Configuration writes (width, height, six Q0.16 weights) go through the
// cfg_valid/cfg_index/cfg_data channel, which is always ready, and must be
// made while the block is idle.
// Sequence: an item that gives no result is accepted and the block stays idle. An
// item that gives a result runs a bit-serial row/column divide, 25 taps, each a
// read through the registered pixel-store read port followed by an accumulate,
// and a 9-step divide of the three channel sums.
// A finished result sits in an output register, so the next item is accepted
// while it waits; if the receiver stalls, the following result holds in the
// block until the register frees. Reset restores the default registers and
// clears the frame counters; the pixel store is not cleared.
module gaussian_blur_rgb_renormalized import gbr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [CH_W-1:0]       pixel_red,
    input  logic [CH_W-1:0]       pixel_green,
    input  logic [CH_W-1:0]       pixel_blue,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [CH_W-1:0]       out_red,
    output logic [CH_W-1:0]       out_green,
    output logic [CH_W-1:0]       out_blue,
    output logic                  frame_last
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    gbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gbr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .sts         (sts),
        .op          (op),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .frame_last  (frame_last)
    );

endmodule

FILE: tb/gaussian_blur_rgb_renormalized_tb.sv
// Self-checking testbench for the renormalized 5x5 RGB blur.
// Depends on gbr_pkg and gaussian_blur_rgb_renormalized; it carries its own blur predictor.
module gaussian_blur_rgb_renormalized_tb;
    import gbr_pkg::*;

    localparam int ITEM_GOAL   = 650;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int SETTLE      = 120;

    // Indexes that name no register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW  = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HIGH = 4'd15;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            fl;
    } blur_px_t;

    typedef struct {
        logic            op;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        bit              typed;
        blur_px_t        want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic op = OP_PIXEL;
    logic [CH_W-1:0] pixel_red = '0, pixel_green = '0, pixel_blue = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [CH_W-1:0] out_red, out_green, out_blue;
    logic frame_last;

    gaussian_blur_rgb_renormalized dut (.*);

    // Predictor state: geometry, weights, pixel store and frame counters.
    logic [DIM_W-1:0] geo_w, geo_h;
    logic [WT_W-1:0]  taps_wt[6];
    logic [PIX_W-1:0] pix_store[LINE_DEPTH];
    int unsigned      taken_cnt, given_cnt;

    blur_px_t pending_px[$];
    int  errors = 0, items_sent = 0, results_seen = 0, frames_done = 0;
    int  cycles = 0, stall_left = 0;
    bit  calm = 1'b0, frame_closed = 1'b0;

    initial forever #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d results pending", $time, pending_px.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 20);
        return $urandom_range(21, 150);
    endfunction

    // The receiver stalls in bursts of random length.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0) stall_left <= pick_gap() + 1;
        end
    end

    always @(posedge clk)
    begin
        blur_px_t w;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (pending_px.size() == 0)
            begin
                $display("%0t unexpected pixel %0d/%0d/%0d last=%0b", $time,
                         out_red, out_green, out_blue, frame_last);
                errors <= errors + 1;
            end
            else
            begin
                w = pending_px.pop_front();
                if ({out_red, out_green, out_blue, frame_last} !== w)
                begin
                    $display("%0t mismatch: expected r=%0d g=%0d b=%0d last=%0b,",
                             $time, w.red, w.green, w.blue, w.fl);
                    $display("    got r=%0d g=%0d b=%0d last=%0b",
                             out_red, out_green, out_blue, frame_last);
                    errors <= errors + 1;
                end
            end
        end
    end

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] d, input int unsigned top);
        if (d == 0) return 1;
        if (d > top) return top;
        return d;
    endfunction

    function automatic longint unsigned tap_weight(input int d2);
        case (d2)
            0: return taps_wt[0];
            1: return taps_wt[1];
            2: return taps_wt[2];
            4: return taps_wt[3];
            5: return taps_wt[4];
            8: return taps_wt[5];
            default: return 0;
        endcase
    endfunction

    function automatic logic [CH_W-1:0] norm_channel(input longint unsigned num,
                                                     input longint unsigned den);
        longint unsigned q, r;
        if (den == 0) return 0;
        q = num / den;
        r = num % den;
        if (2 * r > den || (2 * r == den && q[0])) q++;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Advances the predicted block by one item; returns 1 when it yields a pixel.
    function automatic bit blur_step(input logic is_op, input logic [CH_W-1:0] r,
                                     input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                                     output blur_px_t px);
        int unsigned w, h, n, lag, itm, p;
        int row, col, x, y, dx, dy;
        longint unsigned sr, sg, sb, ws, wt;
        logic [PIX_W-1:0] v;
        w = clamp_dim(geo_w, MAX_WIDTH);
        h = clamp_dim(geo_h, MAX_HEIGHT);
        n = w * h;
        lag = 2 * w + 2;
        sr = 0; sg = 0; sb = 0; ws = 0;
        px = '0;
        if (given_cnt >= n)
        begin
            taken_cnt = 0;
            given_cnt = 0;
        end
        itm = taken_cnt;
        if (itm < n)
        begin
            if (is_op == OP_FLUSH) return 1'b0;
            pix_store[itm % LINE_DEPTH] = {r, g, b};
        end
        if (taken_cnt < COUNT_MAX) taken_cnt++;
        if (itm < lag) return 1'b0;
        p = given_cnt;
        row = p / w;
        col = p % w;
        for (dx = -KHALF; dx < KERNEL_SPAN - KHALF; dx++)
        begin
            x = row + dx;
            if (x < 0 || x >= int'(h)) continue;
            for (dy = -KHALF; dy < KERNEL_SPAN - KHALF; dy++)
            begin
                y = col + dy;
                if (y < 0 || y >= int'(w)) continue;
                wt = tap_weight(dx * dx + dy * dy);
                v = pix_store[(x * w + y) % LINE_DEPTH];
                ws += wt;
                sr += wt * v[23:16];
                sg += wt * v[15:8];
                sb += wt * v[7:0];
            end
        end
        px.red = norm_channel(sr, ws);
        px.green = norm_channel(sg, ws);
        px.blue = norm_channel(sb, ws);
        given_cnt++;
        px.fl = (given_cnt >= n);
        if (px.fl)
        begin
            taken_cnt = 0;
            given_cnt = 0;
        end
        return 1'b1;
    endfunction

    // After each write the configuration channel goes idle before the task returns.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:      geo_w = data[DIM_W-1:0];
            REG_IMAGE_HEIGHT:     geo_h = data[DIM_W-1:0];
            REG_WEIGHT_CENTER:    taps_wt[0] = data;
            REG_WEIGHT_EDGE_NEAR: taps_wt[1] = data;
            REG_WEIGHT_DIAG_NEAR: taps_wt[2] = data;
            REG_WEIGHT_EDGE_FAR:  taps_wt[3] = data;
            REG_WEIGHT_KNIGHT:    taps_wt[4] = data;
            REG_WEIGHT_CORNER:    taps_wt[5] = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Stops sending and waits until every result is in.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_px.size() != 0);
    endtask

    // Waits out any result still being computed before touching registers.
    task automatic go_idle();
        drain_results();
        repeat (SETTLE) @(posedge clk);
    endtask

    // Sends one item and returns the predicted pixel, if any. Valid stays high
    // after the item is taken so that the next item can follow back to back.
    task automatic send_item(input logic o, input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] b, output bit got, output blur_px_t px);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        pixel_red <= r;
        pixel_green <= g;
        pixel_blue <= b;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        got = blur_step(o, r, g, b, px);
        if (got && px.fl) frame_closed = 1'b1;
    endtask

    task automatic send_checked(input logic o, input logic [CH_W-1:0] r,
                                input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
        bit got;
        blur_px_t px;
        send_item(o, r, g, b, got, px);
        if (got) pending_px.push_back(px);
    endtask

    // One whole frame: pixels with stray flushes, then a drain with stray pixels.
    task automatic run_frame(input bit hold_midway);
        int unsigned n, k;
        n = clamp_dim(geo_w, MAX_WIDTH) * clamp_dim(geo_h, MAX_HEIGHT);
        frame_closed = 1'b0;
        calm = ($urandom_range(0, 3) == 0);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_checked(OP_FLUSH, $urandom, $urandom, $urandom);
            if (hold_midway && k == n / 2) drain_results();
            send_checked(OP_PIXEL, $urandom, $urandom, $urandom);
        end
        while (!frame_closed)
        begin
            if ($urandom_range(0, 19) == 0)
                send_checked(OP_PIXEL, $urandom, $urandom, $urandom);
            else
                send_checked(OP_FLUSH, $urandom, $urandom, $urandom);
        end
        frames_done++;
        calm = 1'b0;
    endtask

    task automatic set_weights(input int mode);
        logic [WT_W-1:0] v[6];
        int i;
        for (i = 0; i < 6; i++) v[i] = $urandom;
        case (mode)
            1:
            begin
                v[3] = 0; v[4] = 0; v[5] = 0;
            end
            2: for (i = 1; i < 6; i++) v[i] = 0;
            3: for (i = 0; i < 6; i++) v[i] = 0;
            4: for (i = 0; i < 6; i++) v[i] = 16'hFFFF;
            5:
            begin
                v[0] = 10624; v[1] = 6443; v[2] = 3907;
                v[3] = 1436; v[4] = 871; v[5] = 194;
            end
            default: ;
        endcase
        write_reg(REG_WEIGHT_CENTER, v[0]);
        write_reg(REG_WEIGHT_EDGE_NEAR, v[1]);
        write_reg(REG_WEIGHT_DIAG_NEAR, v[2]);
        write_reg(REG_WEIGHT_EDGE_FAR, v[3]);
        write_reg(REG_WEIGHT_KNIGHT, v[4]);
        write_reg(REG_WEIGHT_CORNER, v[5]);
    endtask

    // 1x1 frames: a lone pixel passes through unchanged, since only the
    // center tap lies inside the image.
    stim_row_t one_px_rows[] = '{
        '{OP_FLUSH, 8'd9,   8'd9,   8'd9,   1'b0, '0},
        '{OP_PIXEL, 8'd255, 8'd0,   8'd128, 1'b0, '0},
        '{OP_PIXEL, 8'd1,   8'd2,   8'd3,   1'b0, '0},
        '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd255, 8'd0, 8'd128, 1'b1}},
        '{OP_PIXEL, 8'd0,   8'd255, 8'd0,   1'b0, '0},
        '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd0, 8'd255, 8'd0, 1'b1}},
        '{OP_PIXEL, 8'd255, 8'd255, 8'd255, 1'b0, '0},
        '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b0, '0},
        '{OP_FLUSH, 8'd0,   8'd0,   8'd0,   1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}}
    };

    initial
    begin
        bit got;
        blur_px_t px;
        int mode;
        geo_w = 640;
        geo_h = 480;
        taps_wt = '{16'd10624, 16'd6443, 16'd3907, 16'd1436, 16'd871, 16'd194};
        taken_cnt = 0;
        given_cnt = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero geometry is treated as one; upper data bits are dropped.
        write_reg(REG_IMAGE_WIDTH, 16'hF000);
        write_reg(REG_IMAGE_HEIGHT, 16'h0000);
        foreach (one_px_rows[i])
        begin
            send_item(one_px_rows[i].op, one_px_rows[i].red, one_px_rows[i].green,
                      one_px_rows[i].blue, got, px);
            if (got) pending_px.push_back(one_px_rows[i].typed ? one_px_rows[i].want : px);
        end
        go_idle();

        // Small frame with all weights zero, then at full scale.
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'h5002);
        write_reg(REG_UNUSED_LOW, 16'hFFFF);
        write_reg(REG_UNUSED_HIGH, 16'h1234);
        set_weights(3);
        run_frame(1'b0);
        go_idle();
        set_weights(4);
        run_frame(1'b1);
        go_idle();

        while (items_sent < ITEM_GOAL)
        begin
            mode = $urandom_range(0, 9);
            if (mode > 5) mode = 0;
            set_weights(mode);
            write_reg(REG_IMAGE_WIDTH,
                      {4'($urandom), 12'(($urandom_range(0, 9) == 0) ?
                                         $urandom_range(9, 40) : $urandom_range(1, 8))});
            write_reg(REG_IMAGE_HEIGHT, {4'($urandom), 12'($urandom_range(1, 6))});
            repeat ($urandom_range(1, 2)) run_frame($urandom_range(0, 5) == 0);
            go_idle();
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        $display("Sent %0d items over %0d frames and checked %0d blurred pixels,", items_sent,
                 frames_done, results_seen);
        $display("covering 1x1 frames up to lines of 40 pixels, zero, partial and full kernels.");
        if (errors == 0 && pending_px.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
